>>> hdl/scfe_pkg.sv
package scfe_pkg;

    // field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 14;
    localparam int SET_W   = 8;
    localparam int ID_W    = 5;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 2;
    localparam int STAT_W  = 3;
    localparam int ADJ_W   = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET_POS     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_SPEED   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_STRETCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ASK_POS     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ASK_SPEED   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ASK_STRETCH = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
    localparam logic [STAT_W-1:0] ST_SKIPPED       = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABOVE_MAX     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BELOW_MIN     = 3'd3;
    localparam logic [STAT_W-1:0] ST_SETTING_RANGE = 3'd4;

    // frame lengths
    localparam logic [LEN_W-1:0] LEN_NONE  = 2'd0;
    localparam logic [LEN_W-1:0] LEN_QUERY = 2'd2;
    localparam logic [LEN_W-1:0] LEN_FULL  = 2'd3;

    // header bases and subcommands
    localparam logic [BYTE_W-1:0] HDR_POS   = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_PARAM = 8'hC0;
    localparam logic [BYTE_W-1:0] HDR_ASK   = 8'hA0;
    localparam logic [BYTE_W-1:0] SUB_POS     = 8'h05;
    localparam logic [BYTE_W-1:0] SUB_SPEED   = 8'h02;
    localparam logic [BYTE_W-1:0] SUB_STRETCH = 8'h01;

    localparam logic [ADJ_W-1:0] NEUTRAL_POS = 16'd7500;

    // register indexes
    localparam logic [2:0] REG_SERVO_ID = 3'd0;
    localparam logic [2:0] REG_OFFSET   = 3'd1;
    localparam logic [2:0] REG_MIN_POS  = 3'd2;
    localparam logic [2:0] REG_MAX_POS  = 3'd3;
    localparam logic [2:0] REG_SKIP_EN  = 3'd4;

    // register reset values
    localparam logic [ID_W-1:0]  RST_SERVO_ID = 5'd0;
    localparam logic [POS_W-1:0] RST_OFFSET   = 14'd7500;
    localparam logic [POS_W-1:0] RST_MIN_POS  = 14'd3500;
    localparam logic [POS_W-1:0] RST_MAX_POS  = 14'd11500;

    typedef struct packed {
        logic [ID_W-1:0]  servo_id;
        logic [POS_W-1:0] position_offset;
        logic [POS_W-1:0] min_position;
        logic [POS_W-1:0] max_position;
        logic             skip_enable;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [SET_W-1:0] setting_value;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] third_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [STAT_W-1:0] status;
    } t_frame;

endpackage

>>> hdl/scfe_if.sv
interface scfe_cmd_if import scfe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [SET_W-1:0] setting_value;

    modport source (output valid, command, position, setting_value, input ready);
    modport sink   (input valid, command, position, setting_value, output ready);
endinterface

interface scfe_frame_if import scfe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] header_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] third_byte;
    logic [LEN_W-1:0]  frame_length;
    logic [STAT_W-1:0] status;

    modport source (output valid, header_byte, second_byte, third_byte, frame_length, status,
                    input ready);
    modport sink   (input valid, header_byte, second_byte, third_byte, frame_length, status,
                    output ready);
endinterface

>>> hdl/scfe_cfg_regs.sv
module scfe_cfg_regs import scfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output logic [PDATA_W-1:0] o_prdata,
    output t_cfg               o_cfg
);

    logic [2:0] reg_index;
    logic       wr_en;
    t_cfg       r_cfg;

    assign reg_index = i_paddr[PADDR_W-1:2];
    assign wr_en     = i_psel && i_penable && i_pwrite;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.servo_id        <= RST_SERVO_ID;
            r_cfg.position_offset <= RST_OFFSET;
            r_cfg.min_position    <= RST_MIN_POS;
            r_cfg.max_position    <= RST_MAX_POS;
            r_cfg.skip_enable     <= 1'b0;
        end else if (wr_en) begin
            case (reg_index)
                REG_SERVO_ID: r_cfg.servo_id        <= i_pwdata[ID_W-1:0];
                REG_OFFSET:   r_cfg.position_offset <= i_pwdata[POS_W-1:0];
                REG_MIN_POS:  r_cfg.min_position    <= i_pwdata[POS_W-1:0];
                REG_MAX_POS:  r_cfg.max_position    <= i_pwdata[POS_W-1:0];
                REG_SKIP_EN:  r_cfg.skip_enable     <= i_pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_index)
            REG_SERVO_ID: o_prdata = {{(PDATA_W-ID_W){1'b0}}, r_cfg.servo_id};
            REG_OFFSET:   o_prdata = {{(PDATA_W-POS_W){1'b0}}, r_cfg.position_offset};
            REG_MIN_POS:  o_prdata = {{(PDATA_W-POS_W){1'b0}}, r_cfg.min_position};
            REG_MAX_POS:  o_prdata = {{(PDATA_W-POS_W){1'b0}}, r_cfg.max_position};
            REG_SKIP_EN:  o_prdata = {{(PDATA_W-1){1'b0}}, r_cfg.skip_enable};
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/scfe_frame_logic.sv
module scfe_frame_logic import scfe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_fire,
    input  t_cmd   i_cmd,
    input  t_cfg   i_cfg,
    output t_frame o_frame
);

    logic [POS_W-1:0]  r_prev_pos;
    logic              r_prev_valid;
    logic              is_skip;
    logic              store_pos;
    logic [ADJ_W-1:0]  pos_sum;
    logic signed [ADJ_W-1:0] adj;
    logic signed [ADJ_W-1:0] max_s;
    logic signed [ADJ_W-1:0] min_s;
    logic              above_max;
    logic              below_min;
    logic              setting_ok;
    logic [BYTE_W-1:0] id_byte;

    assign id_byte = {{(BYTE_W-ID_W){1'b0}}, i_cfg.servo_id};

    // repeated position detect and offset adjust
    assign is_skip   = i_cfg.skip_enable && r_prev_valid && (i_cmd.position == r_prev_pos);
    assign store_pos = i_fire && (i_cmd.command == CMD_SET_POS) && !is_skip;
    assign pos_sum   = {{(ADJ_W-POS_W){1'b0}}, i_cmd.position}
                     + {{(ADJ_W-POS_W){1'b0}}, i_cfg.position_offset};
    assign adj       = $signed(pos_sum - NEUTRAL_POS);
    assign max_s     = $signed({{(ADJ_W-POS_W){1'b0}}, i_cfg.max_position});
    assign min_s     = $signed({{(ADJ_W-POS_W){1'b0}}, i_cfg.min_position});
    assign above_max = adj > max_s;
    assign below_min = (adj < min_s) && (adj != '0);
    assign setting_ok = (i_cmd.setting_value != '0) && !i_cmd.setting_value[SET_W-1];

    // last position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos   <= '0;
            r_prev_valid <= 1'b0;
        end else if (store_pos) begin
            r_prev_pos   <= i_cmd.position;
            r_prev_valid <= 1'b1;
        end
    end

    // frame packing
    always_comb begin
        o_frame = '0;
        case (i_cmd.command)
            CMD_SET_POS: begin
                if (is_skip) begin
                    o_frame.status = ST_SKIPPED;
                end else if (above_max) begin
                    o_frame.status = ST_ABOVE_MAX;
                end else if (below_min) begin
                    o_frame.status = ST_BELOW_MIN;
                end else begin
                    o_frame.header_byte  = HDR_POS | id_byte;
                    o_frame.second_byte  = {1'b0, adj[13:7]};
                    o_frame.third_byte   = {1'b0, adj[6:0]};
                    o_frame.frame_length = LEN_FULL;
                    o_frame.status       = ST_OK;
                end
            end
            CMD_SET_SPEED, CMD_SET_STRETCH: begin
                if (!setting_ok) begin
                    o_frame.status = ST_SETTING_RANGE;
                end else begin
                    o_frame.header_byte  = HDR_PARAM | id_byte;
                    o_frame.second_byte  = (i_cmd.command == CMD_SET_SPEED) ? SUB_SPEED
                                                                             : SUB_STRETCH;
                    o_frame.third_byte   = i_cmd.setting_value;
                    o_frame.frame_length = LEN_FULL;
                end
            end
            CMD_ASK_POS: begin
                o_frame.header_byte  = HDR_ASK | id_byte;
                o_frame.second_byte  = SUB_POS;
                o_frame.frame_length = LEN_QUERY;
            end
            CMD_ASK_SPEED: begin
                o_frame.header_byte  = HDR_ASK | id_byte;
                o_frame.second_byte  = SUB_SPEED;
                o_frame.frame_length = LEN_QUERY;
            end
            CMD_ASK_STRETCH: begin
                o_frame.header_byte  = HDR_ASK | id_byte;
                o_frame.second_byte  = SUB_STRETCH;
                o_frame.frame_length = LEN_QUERY;
            end
            default: o_frame = '0;
        endcase
    end

endmodule

>>> hdl/servo_command_frame_encoder_top.sv
// a command passes the input register, then the result register, before its result is valid
// throughput: one command per cycle, set by the input and result registers
// stalls on the result side hold both stages; a new command is taken whenever the
// input register is empty or moving on
// reset (synchronous, active low) empties the pipeline, clears the last position
// and loads the register defaults
module servo_command_frame_encoder_top import scfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scfe_cmd_if.sink           i_cmd,
    scfe_frame_if.source       o_frame,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg   cfg;
    t_cmd   r_cmd;
    t_frame frame_res;
    t_frame r_frame;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   out_free;
    logic   in_ready;
    logic   fire;

    assign pready = 1'b1;

    scfe_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // pipeline flow control
    assign out_free    = !r_out_valid || o_frame.ready;
    assign fire        = r_in_valid && out_free;
    assign in_ready    = !r_in_valid || out_free;
    assign i_cmd.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_ready && i_cmd.valid) begin
            r_cmd.command       <= i_cmd.command;
            r_cmd.position      <= i_cmd.position;
            r_cmd.setting_value <= i_cmd.setting_value;
        end
    end

    scfe_frame_logic u_logic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_cmd),
        .i_cfg   (cfg),
        .o_frame (frame_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_frame <= frame_res;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.header_byte  = r_frame.header_byte;
    assign o_frame.second_byte  = r_frame.second_byte;
    assign o_frame.third_byte   = r_frame.third_byte;
    assign o_frame.frame_length = r_frame.frame_length;
    assign o_frame.status       = r_frame.status;

endmodule

>>> hdl/scfe_checker.sv
module scfe_checker import scfe_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_header_byte,
    input logic [BYTE_W-1:0] i_second_byte,
    input logic [BYTE_W-1:0] i_third_byte,
    input logic [LEN_W-1:0]  i_frame_length,
    input logic [STAT_W-1:0] i_status
);

    // stalled result keeps its transfer pending
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // rejected or skipped commands carry no frame
    a_status_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> (i_frame_length == LEN_NONE))
        else $error("frame with error status");

    // empty frame has all bytes cleared
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_length == LEN_NONE)
        |-> (i_header_byte == '0 && i_second_byte == '0 && i_third_byte == '0))
        else $error("empty frame with nonzero bytes");

    // query frames are two bytes with a request header
    a_query_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_length == LEN_QUERY)
        |-> (i_third_byte == '0 && i_header_byte[7:5] == HDR_ASK[7:5]))
        else $error("malformed query frame");

endmodule

bind servo_command_frame_encoder_top scfe_checker u_scfe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_frame.valid),
    .i_out_ready    (o_frame.ready),
    .i_header_byte  (o_frame.header_byte),
    .i_second_byte  (o_frame.second_byte),
    .i_third_byte   (o_frame.third_byte),
    .i_frame_length (o_frame.frame_length),
    .i_status       (o_frame.status)
);

>>> bench/servo_command_frame_encoder_checker.sv
`timescale 1ns / 1ps

module servo_command_frame_encoder_checker import scfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_cmd_valid,
    input  logic               i_cmd_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [POS_W-1:0]   i_position,
    input  logic [SET_W-1:0]   i_setting_value,
    // frame channel
    input  logic               i_frame_valid,
    input  logic               i_frame_ready,
    input  logic [BYTE_W-1:0]  i_header_byte,
    input  logic [BYTE_W-1:0]  i_second_byte,
    input  logic [BYTE_W-1:0]  i_third_byte,
    input  logic [LEN_W-1:0]   i_frame_length,
    input  logic [STAT_W-1:0]  i_status,
    // register port
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    // counts handed to the bench top
    output int                 o_mismatches,
    output int                 o_frames_pending,
    output int                 o_frames_checked
);

    localparam int SETTING_LOW  = 1;
    localparam int SETTING_HIGH = 127;

    t_cfg             regs;
    logic [POS_W-1:0] last_position;
    logic             last_position_seen;
    t_frame           expected_frames[$];
    int               mismatch_count = 0;
    int               checked_count  = 0;

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("[%0t] frame %0d: %s", $time, checked_count, msg);
        mismatch_count++;
    endtask

    // register write seen on the config port
    function automatic void apply_register(input logic [2:0] idx,
                                           input logic [PDATA_W-1:0] data);
        case (idx)
            REG_SERVO_ID: regs.servo_id        = data[ID_W-1:0];
            REG_OFFSET:   regs.position_offset = data[POS_W-1:0];
            REG_MIN_POS:  regs.min_position    = data[POS_W-1:0];
            REG_MAX_POS:  regs.max_position    = data[POS_W-1:0];
            REG_SKIP_EN:  regs.skip_enable     = data[0];
            default: ;
        endcase
    endfunction

    // frame that one command should produce; updates the last position
    function automatic t_frame encode_command(input logic [CMD_W-1:0] cmd,
                                              input logic [POS_W-1:0] pos,
                                              input logic [SET_W-1:0] val);
        t_frame            f;
        int                adj;
        logic [POS_W-1:0]  target;
        logic [BYTE_W-1:0] id_bits;
        f       = '0;
        id_bits = {{(BYTE_W-ID_W){1'b0}}, regs.servo_id};
        case (cmd)
            CMD_SET_POS: begin
                if (regs.skip_enable && last_position_seen && pos == last_position) begin
                    f.status = ST_SKIPPED;
                end else begin
                    // stored even if the adjusted value gets rejected
                    last_position      = pos;
                    last_position_seen = 1'b1;
                    adj = int'(pos) + int'(regs.position_offset) - int'(NEUTRAL_POS);
                    if (adj > int'(regs.max_position)) begin
                        f.status = ST_ABOVE_MAX;
                    end else if (adj < int'(regs.min_position) && adj != 0) begin
                        f.status = ST_BELOW_MIN;
                    end else begin
                        target         = adj[POS_W-1:0];
                        f.header_byte  = HDR_POS | id_bits;
                        f.second_byte  = {1'b0, target[POS_W-1:7]};
                        f.third_byte   = {1'b0, target[6:0]};
                        f.frame_length = LEN_FULL;
                        f.status       = ST_OK;
                    end
                end
            end
            CMD_SET_SPEED, CMD_SET_STRETCH: begin
                if (int'(val) < SETTING_LOW || int'(val) > SETTING_HIGH) begin
                    f.status = ST_SETTING_RANGE;
                end else begin
                    f.header_byte  = HDR_PARAM | id_bits;
                    f.second_byte  = (cmd == CMD_SET_SPEED) ? SUB_SPEED : SUB_STRETCH;
                    f.third_byte   = val;
                    f.frame_length = LEN_FULL;
                    f.status       = ST_OK;
                end
            end
            CMD_ASK_POS, CMD_ASK_SPEED, CMD_ASK_STRETCH: begin
                f.header_byte  = HDR_ASK | id_bits;
                f.second_byte  = (cmd == CMD_ASK_POS)   ? SUB_POS :
                                 (cmd == CMD_ASK_SPEED) ? SUB_SPEED : SUB_STRETCH;
                f.frame_length = LEN_QUERY;
                f.status       = ST_OK;
            end
            // unused codes give an all-zero frame and leave the state alone
            default: ;
        endcase
        return f;
    endfunction

    // watch config writes, command and frame transfers
    always @(posedge i_clk) begin : monitor
        t_frame want;
        if (!i_rst_n) begin
            expected_frames.delete();
            regs.servo_id        = RST_SERVO_ID;
            regs.position_offset = RST_OFFSET;
            regs.min_position    = RST_MIN_POS;
            regs.max_position    = RST_MAX_POS;
            regs.skip_enable     = 1'b0;
            last_position        = '0;
            last_position_seen   = 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                apply_register(i_paddr[PADDR_W-1:2], i_pwdata);
            end
            if (i_cmd_valid && i_cmd_ready) begin
                expected_frames.push_back(encode_command(i_command, i_position,
                                                         i_setting_value));
            end
            if (i_frame_valid && i_frame_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("frame transfer with none expected, header 0x%0h",
                                              i_header_byte));
                end else begin
                    want = expected_frames.pop_front();
                    if (i_header_byte !== want.header_byte)
                        report_mismatch($sformatf("header_byte got 0x%0h expected 0x%0h",
                                                  i_header_byte, want.header_byte));
                    if (i_second_byte !== want.second_byte)
                        report_mismatch($sformatf("second_byte got 0x%0h expected 0x%0h",
                                                  i_second_byte, want.second_byte));
                    if (i_third_byte !== want.third_byte)
                        report_mismatch($sformatf("third_byte got 0x%0h expected 0x%0h",
                                                  i_third_byte, want.third_byte));
                    if (i_frame_length !== want.frame_length)
                        report_mismatch($sformatf("frame_length got %0d expected %0d",
                                                  i_frame_length, want.frame_length));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  i_status, want.status));
                    checked_count++;
                end
            end
        end
        o_frames_pending <= expected_frames.size();
        o_mismatches     <= mismatch_count;
        o_frames_checked <= checked_count;
    end

endmodule

>>> bench/servo_command_frame_encoder_top_tb.sv
`timescale 1ns / 1ps

module servo_command_frame_encoder_top_tb;
    import scfe_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    localparam int ID_MAX        = (1 << ID_W) - 1;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    scfe_cmd_if   cmd_if ();
    scfe_frame_if frame_if ();

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int directed_items;
    int settings_used = 0;
    int offset_now    = int'(RST_OFFSET);
    int min_now       = int'(RST_MIN_POS);
    int max_now       = int'(RST_MAX_POS);
    int cycle_count;
    int mismatches;
    int frames_pending;
    int frames_checked;
    logic [POS_W-1:0] last_sent_position = '0;

    always #HALF_PERIOD i_clk = ~i_clk;

    servo_command_frame_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_frame (frame_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    servo_command_frame_encoder_checker u_frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_if.valid),
        .i_cmd_ready      (cmd_if.ready),
        .i_command        (cmd_if.command),
        .i_position       (cmd_if.position),
        .i_setting_value  (cmd_if.setting_value),
        .i_frame_valid    (frame_if.valid),
        .i_frame_ready    (frame_if.ready),
        .i_header_byte    (frame_if.header_byte),
        .i_second_byte    (frame_if.second_byte),
        .i_third_byte     (frame_if.third_byte),
        .i_frame_length   (frame_if.frame_length),
        .i_status         (frame_if.status),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatches     (mismatches),
        .o_frames_pending (frames_pending),
        .o_frames_checked (frames_checked)
    );

    // frame receiver: random stalls, plus long hold-offs on request
    initial begin
        frame_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                frame_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES - 1;
                frame_if.ready <= 1'b0;
            end else begin
                frame_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("servo_command_frame_encoder_top test failed");
        $finish;
    end

    // register write: setup phase, then access phase held until pready
    task automatic write_register(input logic [2:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_registers(input int id, input int offset, input int min_pos,
                                 input int max_pos, input int skip);
        write_register(REG_SERVO_ID, id);
        write_register(REG_OFFSET, offset);
        write_register(REG_MIN_POS, min_pos);
        write_register(REG_MAX_POS, max_pos);
        write_register(REG_SKIP_EN, skip);
        offset_now = offset;
        min_now    = min_pos;
        max_now    = max_pos;
        settings_used++;
    endtask

    // one command transfer, with random idle cycles ahead of it
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [SET_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid         <= 1'b0;
            cmd_if.command       <= CMD_W'($urandom);
            cmd_if.position      <= POS_W'($urandom);
            cmd_if.setting_value <= SET_W'($urandom);
            @(posedge i_clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= cmd;
        cmd_if.position      <= pos;
        cmd_if.setting_value <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        if (cmd == CMD_SET_POS) last_sent_position = pos;
        items_sent++;
    endtask

    // stop offering and wait for every frame to come out
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (frames_pending != 0) @(posedge i_clk);
    endtask

    // raw position that lands on a given adjusted value, random if out of reach
    function automatic logic [POS_W-1:0] aim_position(input int adjusted);
        int raw;
        raw = adjusted + int'(NEUTRAL_POS) - offset_now;
        if (raw < 0 || raw > POS_MAX) raw = $urandom_range(POS_MAX);
        return raw[POS_W-1:0];
    endfunction

    // random command biased toward repeats and range boundaries
    task automatic random_command(output logic [CMD_W-1:0] cmd,
                                  output logic [POS_W-1:0] pos,
                                  output logic [SET_W-1:0] val);
        int pick;
        pos  = POS_W'($urandom);
        val  = SET_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) begin
            cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        end else if (pick < 55) begin
            cmd = CMD_SET_POS;
            case ($urandom_range(9))
                0, 1: pos = last_sent_position;
                2: pos = aim_position(min_now);
                3: pos = aim_position(min_now - 1);
                4: pos = aim_position(max_now);
                5: pos = aim_position(max_now + 1);
                6: pos = aim_position(0);
                default: ;
            endcase
        end else if (pick < 75) begin
            cmd = $urandom_range(1) ? CMD_SET_SPEED : CMD_SET_STRETCH;
            case ($urandom_range(7))
                0: val = '0;
                1: val = 8'd1;
                2: val = 8'd127;
                3: val = 8'd128;
                4: val = '1;
                5, 6: val = SET_W'($urandom_range(1, 127));
                default: ;
            endcase
        end else begin
            case ($urandom_range(2))
                0: cmd = CMD_ASK_POS;
                1: cmd = CMD_ASK_SPEED;
                default: cmd = CMD_ASK_STRETCH;
            endcase
        end
    endtask

    // field extremes, every command, skip and rejection cases
    task automatic run_directed();
        send_idle_pct = 20;
        rx_stall_pct  = 20;
        // skip enabled before any position: first zero goes out, second is skipped
        write_register(REG_SKIP_EN, 1);
        send_command(CMD_SET_POS, 14'd0, 8'd0);
        send_command(CMD_SET_POS, 14'd0, 8'd0);
        wait_drained();
        write_register(REG_SKIP_EN, 0);
        // window edges at default offset
        send_command(CMD_SET_POS, 14'd3500, 8'd0);
        send_command(CMD_SET_POS, 14'd3499, 8'd0);
        send_command(CMD_SET_POS, 14'd11500, 8'd0);
        send_command(CMD_SET_POS, 14'd11501, 8'd0);
        send_command(CMD_SET_POS, POS_W'(POS_MAX), 8'd0);
        send_command(CMD_SET_POS, 14'd1, 8'd0);
        // setting range
        send_command(CMD_SET_SPEED, 14'd0, 8'd0);
        send_command(CMD_SET_SPEED, 14'd0, 8'd1);
        send_command(CMD_SET_SPEED, 14'd0, 8'd127);
        send_command(CMD_SET_SPEED, 14'd0, 8'd128);
        send_command(CMD_SET_STRETCH, 14'd0, 8'd255);
        send_command(CMD_SET_STRETCH, 14'd0, 8'd64);
        // queries and unused codes
        send_command(CMD_ASK_POS, 14'd0, 8'd0);
        send_command(CMD_ASK_SPEED, 14'd0, 8'd0);
        send_command(CMD_ASK_STRETCH, 14'd0, 8'd0);
        send_command(CMD_UNUSED_LO, POS_W'(POS_MAX), 8'd255);
        send_command(CMD_UNUSED_HI, 14'd0, 8'd0);
        wait_drained();
        // negative adjusted value, stored even though rejected, so repeat is skipped
        set_registers(ID_MAX, 0, int'(RST_MIN_POS), int'(RST_MAX_POS), 1);
        send_command(CMD_SET_POS, 14'd100, 8'd0);
        send_command(CMD_SET_POS, 14'd100, 8'd0);
        send_command(CMD_UNUSED_HI, 14'd200, 8'd0);
        send_command(CMD_SET_POS, 14'd100, 8'd0);
        send_command(CMD_SET_POS, POS_W'(POS_MAX), 8'd0);
        send_command(CMD_ASK_STRETCH, 14'd0, 8'd0);
        wait_drained();
        directed_items = items_sent;
    endtask

    task automatic pick_phase_setup(input int phase);
        int lo;
        int hi;
        case (phase)
            0: set_registers(ID_MAX, int'(RST_OFFSET), int'(RST_MIN_POS), int'(RST_MAX_POS), 1);
            1: set_registers(0, 0, 0, POS_MAX, 0);
            2: set_registers($urandom_range(ID_MAX), POS_MAX, POS_MAX, POS_MAX, 1);
            3: set_registers($urandom_range(ID_MAX), int'(RST_OFFSET), 0, 0, 1);
            default: begin
                lo = $urandom_range(8000);
                hi = $urandom_range(lo, POS_MAX);
                set_registers($urandom_range(ID_MAX), $urandom_range(3500, 11500), lo, hi,
                              $urandom_range(1));
            end
        endcase
        // idle patterns cycle: none, sender, receiver, both lightly
        case (phase % 4)
            0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rx_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rx_stall_pct = 72; end
            default: begin send_idle_pct = 11; rx_stall_pct = 11; end
        endcase
    endtask

    // stimulus
    initial begin
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [SET_W-1:0] val;
        int               counted;
        int               idx;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        cmd_if.valid         <= 1'b0;
        cmd_if.command       <= '0;
        cmd_if.position      <= '0;
        cmd_if.setting_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            pick_phase_setup(phase);
            counted = 0;
            idx     = 0;
            while (counted < PHASE_ITEMS) begin
                // long receiver hold-off while commands keep coming
                if (idx == 20 && send_idle_pct == 0) hold_requests <= hold_requests + 1;
                // one full pause until every frame is out
                if (idx == 35 && phase == 1) wait_drained();
                random_command(cmd, pos, val);
                send_command(cmd, pos, val);
                if (cmd <= CMD_ASK_STRETCH) counted++;
                idx++;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d commands, %0d of them directed, over %0d register settings",
                 items_sent, directed_items, settings_used);
        $display("compared %0d frames under four idle patterns, %0d mismatches",
                 frames_checked, mismatches);
        if (mismatches == 0 && frames_pending == 0) begin
            $display("servo_command_frame_encoder_top test passed");
        end else begin
            $display("servo_command_frame_encoder_top test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/scfe_pkg.sv
hdl/scfe_if.sv
hdl/scfe_cfg_regs.sv
hdl/scfe_frame_logic.sv
hdl/servo_command_frame_encoder_top.sv
hdl/scfe_checker.sv
bench/servo_command_frame_encoder_checker.sv
bench/servo_command_frame_encoder_top_tb.sv
